>>> design/tcmi_pkg.sv
// ----------------------------------------------------------------------------
// tcmi_pkg
// Shared types and constants of the tilt compensated motion integrator.
// ----------------------------------------------------------------------------
package tcmi_pkg;

   // Field widths of the channels.
   localparam int SAMPLE_WIDTH = 16;
   localparam int TILT_WIDTH   = 16;
   localparam int NOISE_WIDTH  = 21;
   localparam int ACCEL_WIDTH  = 22;
   localparam int SPEED_WIDTH  = 48;
   localparam int PLACE_WIDTH  = 64;

   // Request commands.
   typedef enum logic {CMD_TICK = 1'b0, CMD_CLEAR = 1'b1} motion_cmd_type;

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = NOISE_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TILT_COS_X  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TILT_SIN_X  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TILT_COS_Y  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TILT_SIN_Y  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NOISE_FLOOR = 3'd4;

   // Register reset values.
   localparam logic signed [TILT_WIDTH-1:0] TILT_COS_RESET    = 16'sd16384;
   localparam logic signed [TILT_WIDTH-1:0] TILT_SIN_RESET    = 16'sd0;
   localparam logic [NOISE_WIDTH-1:0]       NOISE_FLOOR_RESET = 21'd6554;

   // Standard gravity in Q16 m/s^2 and the rounding of the Q44 product.
   localparam int GRAV_WIDTH  = 21;
   localparam logic signed [GRAV_WIDTH-1:0] GRAV_Q16 = 21'sd642689;
   localparam int SUM_WIDTH   = SAMPLE_WIDTH + 1;
   localparam int PROD1_WIDTH = SUM_WIDTH + TILT_WIDTH;
   localparam int PROD2_WIDTH = PROD1_WIDTH + GRAV_WIDTH;
   localparam int ROUND_SHIFT = 28;
   localparam int SCALED_WIDTH = PROD2_WIDTH - ROUND_SHIFT;
   localparam logic signed [PROD2_WIDTH-1:0] ROUND_HALF =
      PROD2_WIDTH'(64'sd1 <<< (ROUND_SHIFT - 1));

   localparam logic signed [ACCEL_WIDTH-1:0] ACCEL_MAX = {1'b0, {(ACCEL_WIDTH-1){1'b1}}};
   localparam logic signed [ACCEL_WIDTH-1:0] ACCEL_MIN = {1'b1, {(ACCEL_WIDTH-1){1'b0}}};

   // Depth of the acceleration pipeline ahead of the motion state.
   localparam int ACCEL_STAGES = 5;

   // Zero acceleration run that forces velocity to zero.
   localparam int WINDOW_DEPTH = 64;
   localparam int RUN_WIDTH    = $clog2(WINDOW_DEPTH + 1);
   localparam logic [RUN_WIDTH-1:0] RUN_FULL = RUN_WIDTH'(WINDOW_DEPTH);

   // Current tilt and noise settings.
   typedef struct packed {
      logic signed [TILT_WIDTH-1:0] cos_x;
      logic signed [TILT_WIDTH-1:0] sin_x;
      logic signed [TILT_WIDTH-1:0] cos_y;
      logic signed [TILT_WIDTH-1:0] sin_y;
      logic [NOISE_WIDTH-1:0]       noise_floor;
   } tilt_cfg_type;

   // One beat leaving the acceleration pipeline.
   typedef struct packed {
      logic                          cmd;
      logic signed [ACCEL_WIDTH-1:0] accel_x;
      logic signed [ACCEL_WIDTH-1:0] accel_y;
   } accel_beat_type;

endpackage

>>> design/tcmi_req_if.sv
// ----------------------------------------------------------------------------
// tcmi_req_if
// Sample channel: command and one two-axis accelerometer sample per beat.
// ----------------------------------------------------------------------------
interface tcmi_req_if;
   import tcmi_pkg::*;

   logic                           valid;
   logic                           ready;
   logic                           cmd;
   logic signed [SAMPLE_WIDTH-1:0] accel_x;
   logic signed [SAMPLE_WIDTH-1:0] accel_y;

   modport source (output valid, output cmd, output accel_x, output accel_y, input ready);
   modport sink   (input valid, input cmd, input accel_x, input accel_y, output ready);
endinterface

>>> design/tcmi_rsp_if.sv
// ----------------------------------------------------------------------------
// tcmi_rsp_if
// Result channel: compensated acceleration, velocity and position per beat.
// ----------------------------------------------------------------------------
interface tcmi_rsp_if;
   import tcmi_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [ACCEL_WIDTH-1:0] lin_accel_x;
   logic signed [ACCEL_WIDTH-1:0] lin_accel_y;
   logic signed [SPEED_WIDTH-1:0] speed_x;
   logic signed [SPEED_WIDTH-1:0] speed_y;
   logic signed [PLACE_WIDTH-1:0] place_x;
   logic signed [PLACE_WIDTH-1:0] place_y;

   modport source (output valid, output lin_accel_x, output lin_accel_y, output speed_x,
                   output speed_y, output place_x, output place_y, input ready);
   modport sink   (input valid, input lin_accel_x, input lin_accel_y, input speed_x,
                   input speed_y, input place_x, input place_y, output ready);
endinterface

>>> design/tcmi_csr_if.sv
// ----------------------------------------------------------------------------
// tcmi_csr_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface tcmi_csr_if;
   import tcmi_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/tcmi_csr.sv
// ----------------------------------------------------------------------------
// tcmi_csr
// Tilt and noise floor registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module tcmi_csr (
   input  logic                  clock,
   input  logic                  reset,
   tcmi_csr_if.sink              csr_bus,
   output tcmi_pkg::tilt_cfg_type cfg
);
   import tcmi_pkg::*;

   tilt_cfg_type cfg_ff;

   // Writes are always taken; unknown indexes are dropped.
   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_x       <= TILT_COS_RESET;
         cfg_ff.sin_x       <= TILT_SIN_RESET;
         cfg_ff.cos_y       <= TILT_COS_RESET;
         cfg_ff.sin_y       <= TILT_SIN_RESET;
         cfg_ff.noise_floor <= NOISE_FLOOR_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_TILT_COS_X:  cfg_ff.cos_x       <= csr_bus.data[TILT_WIDTH-1:0];
            CSR_TILT_SIN_X:  cfg_ff.sin_x       <= csr_bus.data[TILT_WIDTH-1:0];
            CSR_TILT_COS_Y:  cfg_ff.cos_y       <= csr_bus.data[TILT_WIDTH-1:0];
            CSR_TILT_SIN_Y:  cfg_ff.sin_y       <= csr_bus.data[TILT_WIDTH-1:0];
            CSR_NOISE_FLOOR: cfg_ff.noise_floor <= csr_bus.data[NOISE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

endmodule

>>> design/tcmi_accel.sv
// ----------------------------------------------------------------------------
// tcmi_accel
// Five stage pipeline from raw sample to compensated, noise gated acceleration.
// ----------------------------------------------------------------------------
module tcmi_accel (
   input  logic                    clock,
   input  logic                    reset,
   tcmi_req_if.sink                req_bus,
   input  tcmi_pkg::tilt_cfg_type  cfg,
   output tcmi_pkg::accel_beat_type beat,
   output logic                    beat_valid,
   input  logic                    beat_ready
);
   import tcmi_pkg::*;

   logic [ACCEL_STAGES-1:0] valid_ff;
   logic [ACCEL_STAGES-1:0] load;

   // Stage 0: input register.
   logic                           cmd0_ff;
   logic signed [SAMPLE_WIDTH-1:0] sx0_ff, sy0_ff;
   // Stage 1: tilt cosine times corrected sample.
   logic                           cmd1_ff;
   logic signed [PROD1_WIDTH-1:0]  px1_ff, py1_ff, px1_in, py1_in;
   logic signed [SUM_WIDTH-1:0]    sum_x, sum_y;
   // Stage 2: scaled by gravity.
   logic                           cmd2_ff;
   logic signed [PROD2_WIDTH-1:0]  px2_ff, py2_ff;
   // Stage 3: rounded and saturated.
   logic                           cmd3_ff;
   logic signed [ACCEL_WIDTH-1:0]  ax3_ff, ay3_ff, ax3_in, ay3_in;
   logic signed [PROD2_WIDTH-1:0]  rnd_x, rnd_y;
   logic signed [SCALED_WIDTH-1:0] scl_x, scl_y;
   // Stage 4: noise floor applied.
   logic                           cmd4_ff;
   logic signed [ACCEL_WIDTH-1:0]  ax4_ff, ay4_ff, ax4_in, ay4_in;
   logic [ACCEL_WIDTH-1:0]         mag_x, mag_y, floor_ext;

   // A stage loads when it is empty or its beat moves on.
   always_comb begin
      load[ACCEL_STAGES-1] = !valid_ff[ACCEL_STAGES-1] || beat_ready;
      for (int k = ACCEL_STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   assign req_bus.ready = load[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (load[0]) valid_ff[0] <= req_bus.valid;
         for (int k = 1; k < ACCEL_STAGES; k++) begin
            if (load[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // Gravity share removal: x adds the sine, y subtracts it.
   always_comb begin
      sum_x  = SUM_WIDTH'(sx0_ff) + SUM_WIDTH'(cfg.sin_x);
      sum_y  = SUM_WIDTH'(sy0_ff) - SUM_WIDTH'(cfg.sin_y);
      px1_in = PROD1_WIDTH'(sum_x) * PROD1_WIDTH'(cfg.cos_x);
      py1_in = PROD1_WIDTH'(sum_y) * PROD1_WIDTH'(cfg.cos_y);
   end

   // Round half up from Q44 to Q16, then saturate to the acceleration range.
   always_comb begin
      rnd_x = px2_ff + ROUND_HALF;
      rnd_y = py2_ff + ROUND_HALF;
      scl_x = rnd_x[PROD2_WIDTH-1:ROUND_SHIFT];
      scl_y = rnd_y[PROD2_WIDTH-1:ROUND_SHIFT];
      if (scl_x[SCALED_WIDTH-1:ACCEL_WIDTH-1] != {(SCALED_WIDTH-ACCEL_WIDTH+1){scl_x[SCALED_WIDTH-1]}})
         ax3_in = scl_x[SCALED_WIDTH-1] ? ACCEL_MIN : ACCEL_MAX;
      else
         ax3_in = scl_x[ACCEL_WIDTH-1:0];
      if (scl_y[SCALED_WIDTH-1:ACCEL_WIDTH-1] != {(SCALED_WIDTH-ACCEL_WIDTH+1){scl_y[SCALED_WIDTH-1]}})
         ay3_in = scl_y[SCALED_WIDTH-1] ? ACCEL_MIN : ACCEL_MAX;
      else
         ay3_in = scl_y[ACCEL_WIDTH-1:0];
   end

   // Magnitudes strictly below the noise floor read as zero.
   always_comb begin
      floor_ext = ACCEL_WIDTH'(cfg.noise_floor);
      mag_x     = ax3_ff[ACCEL_WIDTH-1] ? ACCEL_WIDTH'(-ax3_ff) : ACCEL_WIDTH'(ax3_ff);
      mag_y     = ay3_ff[ACCEL_WIDTH-1] ? ACCEL_WIDTH'(-ay3_ff) : ACCEL_WIDTH'(ay3_ff);
      ax4_in    = (mag_x < floor_ext) ? '0 : ax3_ff;
      ay4_in    = (mag_y < floor_ext) ? '0 : ay3_ff;
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      if (load[0] && req_bus.valid) begin
         cmd0_ff <= req_bus.cmd;
         sx0_ff  <= req_bus.accel_x;
         sy0_ff  <= req_bus.accel_y;
      end
      if (load[1] && valid_ff[0]) begin
         cmd1_ff <= cmd0_ff;
         px1_ff  <= px1_in;
         py1_ff  <= py1_in;
      end
      if (load[2] && valid_ff[1]) begin
         cmd2_ff <= cmd1_ff;
         px2_ff  <= PROD2_WIDTH'(px1_ff) * PROD2_WIDTH'(GRAV_Q16);
         py2_ff  <= PROD2_WIDTH'(py1_ff) * PROD2_WIDTH'(GRAV_Q16);
      end
      if (load[3] && valid_ff[2]) begin
         cmd3_ff <= cmd2_ff;
         ax3_ff  <= ax3_in;
         ay3_ff  <= ay3_in;
      end
      if (load[4] && valid_ff[3]) begin
         cmd4_ff <= cmd3_ff;
         ax4_ff  <= ax4_in;
         ay4_ff  <= ay4_in;
      end
   end

   assign beat_valid   = valid_ff[ACCEL_STAGES-1];
   assign beat.cmd     = cmd4_ff;
   assign beat.accel_x = ax4_ff;
   assign beat.accel_y = ay4_ff;

endmodule

>>> design/tcmi_axis.sv
// ----------------------------------------------------------------------------
// tcmi_axis
// Motion state of one axis: last acceleration, velocity, position, zero run.
// ----------------------------------------------------------------------------
module tcmi_axis (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  step,
   input  logic                                  clear,
   input  logic                                  first,
   input  logic signed [tcmi_pkg::ACCEL_WIDTH-1:0] accel,
   output logic signed [tcmi_pkg::ACCEL_WIDTH-1:0] lin_accel,
   output logic signed [tcmi_pkg::SPEED_WIDTH-1:0] speed,
   output logic signed [tcmi_pkg::PLACE_WIDTH-1:0] place
);
   import tcmi_pkg::*;

   logic signed [ACCEL_WIDTH-1:0] la_ff;
   logic signed [SPEED_WIDTH-1:0] vel_ff, vel_in;
   logic signed [PLACE_WIDTH-1:0] pos_ff, pos_in;
   logic [RUN_WIDTH-1:0]          run_ff, run_in;
   logic signed [SPEED_WIDTH:0]   vel_sum;
   logic signed [PLACE_WIDTH:0]   pos_sum;

   // Zero run counter saturates at the window depth.
   always_comb begin
      if (accel != '0)
         run_in = '0;
      else if (run_ff < RUN_FULL)
         run_in = run_ff + RUN_WIDTH'(1);
      else
         run_in = run_ff;
   end

   // Velocity integrates the previous acceleration, position the previous velocity.
   always_comb begin
      vel_sum = (SPEED_WIDTH+1)'(vel_ff) + (SPEED_WIDTH+1)'(la_ff);
      pos_sum = (PLACE_WIDTH+1)'(pos_ff) + (PLACE_WIDTH+1)'(vel_ff);
      if (vel_sum[SPEED_WIDTH] != vel_sum[SPEED_WIDTH-1])
         vel_in = vel_sum[SPEED_WIDTH] ? {1'b1, {(SPEED_WIDTH-1){1'b0}}}
                                       : {1'b0, {(SPEED_WIDTH-1){1'b1}}};
      else
         vel_in = vel_sum[SPEED_WIDTH-1:0];
      if (run_in >= RUN_FULL)
         vel_in = '0;
      if (pos_sum[PLACE_WIDTH] != pos_sum[PLACE_WIDTH-1])
         pos_in = pos_sum[PLACE_WIDTH] ? {1'b1, {(PLACE_WIDTH-1){1'b0}}}
                                       : {1'b0, {(PLACE_WIDTH-1){1'b1}}};
      else
         pos_in = pos_sum[PLACE_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         la_ff  <= '0;
         vel_ff <= '0;
         pos_ff <= '0;
         run_ff <= RUN_FULL;
      end else if (step) begin
         la_ff  <= accel;
         run_ff <= run_in;
         if (!first) begin
            vel_ff <= vel_in;
            pos_ff <= pos_in;
         end
      end
   end

   assign lin_accel = la_ff;
   assign speed     = vel_ff;
   assign place     = pos_ff;

endmodule

>>> design/tilt_compensated_motion_integrator.sv
// ----------------------------------------------------------------------------
// tilt_compensated_motion_integrator
// Two-axis accelerometer dead reckoning with tilt compensation.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one beat per sensor tick: cmd 0 is a sample (accel_x,
//   accel_y in Q2.14 g), cmd 1 clears all motion state and returns zeros.
//   rsp_bus returns exactly one beat per request beat, in order: the
//   compensated acceleration and the updated velocity and position.
//   csr_bus writes the tilt cosines and sines and the noise floor; it is
//   always ready and should only be written while no request is in flight.
// Timing:
//   A request accepted on req_bus passes the input register, tilt product,
//   gravity product, rounding and saturation, noise gate, then the motion
//   state which is the output register. One beat per cycle is accepted and
//   delivered sustained while the receiver holds rsp ready high.
// Reset and stall:
//   Reset restores the register defaults and clears all motion state.
//   While the receiver holds rsp ready low the result beat holds steady and
//   the pipeline keeps filling its empty stages; req ready drops once all
//   stages are full.
// ----------------------------------------------------------------------------
module tilt_compensated_motion_integrator (
   input  logic     clock,
   input  logic     reset,
   tcmi_req_if.sink req_bus,
   tcmi_rsp_if.source rsp_bus,
   tcmi_csr_if.sink csr_bus
);
   import tcmi_pkg::*;

   tilt_cfg_type   cfg;
   accel_beat_type beat;
   logic           beat_valid;
   logic           out_load;
   logic           take;
   logic           step;
   logic           clear;
   logic           rsp_valid_ff;
   logic           first_sample_ff;

   tcmi_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   tcmi_accel u_accel (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .cfg        (cfg),
      .beat       (beat),
      .beat_valid (beat_valid),
      .beat_ready (out_load)
   );

   // The motion state is the result register; it advances when the slot frees.
   assign out_load = !rsp_valid_ff || rsp_bus.ready;
   assign take     = beat_valid && out_load;
   assign step     = take && (beat.cmd == CMD_TICK);
   assign clear    = take && (beat.cmd == CMD_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         first_sample_ff <= 1'b1;
      end else begin
         if (out_load) rsp_valid_ff <= beat_valid;
         if (clear)
            first_sample_ff <= 1'b1;
         else if (step)
            first_sample_ff <= 1'b0;
      end
   end

   tcmi_axis u_axis_x (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .clear     (clear),
      .first     (first_sample_ff),
      .accel     (beat.accel_x),
      .lin_accel (rsp_bus.lin_accel_x),
      .speed     (rsp_bus.speed_x),
      .place     (rsp_bus.place_x)
   );

   tcmi_axis u_axis_y (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .clear     (clear),
      .first     (first_sample_ff),
      .accel     (beat.accel_y),
      .lin_accel (rsp_bus.lin_accel_y),
      .speed     (rsp_bus.speed_y),
      .place     (rsp_bus.place_y)
   );

   assign rsp_bus.valid = rsp_valid_ff;

endmodule
